// File: rtl/vurp_pkg.sv
// ----------------------------------------------------------------------------
// vurp_pkg
// Shared constants and types of the video unit register port.
// ----------------------------------------------------------------------------
package vurp_pkg;

  localparam int unsigned NAME_TABLE_BYTES_DEF = 2048;
  localparam int unsigned SPRITE_BYTES = 256;
  localparam int unsigned PALETTE_BYTES = 32;
  localparam int unsigned SpriteAw = $clog2(SPRITE_BYTES);
  localparam int unsigned PaletteAw = $clog2(PALETTE_BYTES);

  localparam logic FUNC_READ = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR = 3'd6;
  localparam logic [2:0] REG_DATA = 3'd7;

  localparam logic [7:0] STATUS_FIRST = 8'hC0;
  localparam logic [13:0] NT_START = 14'h2000;
  localparam logic [13:0] PALETTE_START = 14'h3F00;
  localparam logic [15:0] STEP_NARROW = 16'd1;
  localparam logic [15:0] STEP_WIDE = 16'd32;
  localparam int unsigned CTRL_STEP_BIT = 2;

  typedef enum logic [2:0] {
    REGION_PATTERN = 3'b001,
    REGION_TABLE   = 3'b010,
    REGION_PALETTE = 3'b100
  } region_e;

  typedef enum logic [2:0] {
    SRC_FIXED,
    SRC_SPRITE,
    SRC_LATCH_EXT,
    SRC_LATCH_MEM,
    SRC_PALETTE
  } result_src_e;

endpackage

// File: rtl/vurp_if.sv
// ----------------------------------------------------------------------------
// vurp_req_if / vurp_rsp_if
// Valid-ready channels for bus accesses and returned bytes.
// ----------------------------------------------------------------------------
interface vurp_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] pattern_byte;

  modport source (output valid, func, reg_index, write_data, pattern_byte, input ready);
  modport sink (input valid, func, reg_index, write_data, pattern_byte, output ready);
endinterface

interface vurp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: rtl/vurp_addr_map.sv
// ----------------------------------------------------------------------------
// vurp_addr_map
// Maps the current video address to a region and a video memory index.
// Name-table entries come first, the palette follows them.
// ----------------------------------------------------------------------------
module vurp_addr_map #(
  parameter int unsigned NAME_TABLE_BYTES = vurp_pkg::NAME_TABLE_BYTES_DEF,
  localparam int unsigned VmemAw = $clog2(NAME_TABLE_BYTES + vurp_pkg::PALETTE_BYTES)
) (
  input  logic [15:0]           video_address_i,
  output vurp_pkg::region_e     region_o,
  output logic [VmemAw-1:0]     index_o
);
  import vurp_pkg::*;

  localparam int unsigned FoldSteps = 7936 / NAME_TABLE_BYTES;

  logic [13:0]          addr;
  logic [12:0]          fold;
  logic [PaletteAw-1:0] slot;

  assign addr = video_address_i[13:0];

  always_comb begin
    fold = addr[12:0];
    for (int k = 0; k < FoldSteps; k++) begin
      if (fold >= 13'(NAME_TABLE_BYTES)) begin
        fold = fold - 13'(NAME_TABLE_BYTES);
      end
    end
  end

  always_comb begin
    slot = addr[PaletteAw-1:0];
    if (slot[4] && slot[1:0] == 2'b00) begin
      slot[4] = 1'b0;
    end
  end

  always_comb begin
    if (addr < NT_START) begin
      region_o = REGION_PATTERN;
      index_o  = VmemAw'(fold);
    end else if (addr < PALETTE_START) begin
      region_o = REGION_TABLE;
      index_o  = VmemAw'(fold);
    end else begin
      region_o = REGION_PALETTE;
      index_o  = VmemAw'(NAME_TABLE_BYTES) + VmemAw'(slot);
    end
  end

endmodule

// File: rtl/video_unit_register_port.sv
// ----------------------------------------------------------------------------
// video_unit_register_port
// CPU-facing register port of a tile video unit with name-table, palette
// and sprite memories.
//
//   channel | modport | payload
//   req_i   | sink    | func, reg_index, write_data, pattern_byte
//   rsp_o   | source  | read_data
//
// One transfer on req_i gives one on rsp_o, through the s1 and output stages.
// A new access is taken every cycle while rsp_o is not stalled; the limit is
// the single port of each memory, read in the cycle of the transfer and used
// when s1 advances. Reset clears all control registers, memories are kept.
// A stall on rsp_o holds the output stage, then s1 and then req_i.
// ----------------------------------------------------------------------------
module video_unit_register_port #(
  parameter int unsigned NAME_TABLE_BYTES = vurp_pkg::NAME_TABLE_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vurp_req_if.sink      req_i,
  vurp_rsp_if.source    rsp_o
);
  import vurp_pkg::*;

  localparam int unsigned VmemDepth = NAME_TABLE_BYTES + PALETTE_BYTES;
  localparam int unsigned VmemAw = $clog2(VmemDepth);

  logic [7:0]  vmem [VmemDepth];
  logic [7:0]  smem [SPRITE_BYTES];
  logic [7:0]  vmem_rd_q;
  logic [7:0]  smem_rd_q;

  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  spr_idx_q, spr_idx_d;
  logic [14:0] staged_q, staged_d;
  logic [15:0] vaddr_q, vaddr_d;
  logic        toggle_q, toggle_d;
  logic        phase_q, phase_d;
  logic [7:0]  latch_q, latch_d;

  logic        s1_valid_q;
  result_src_e s1_src_q, s1_src_d;
  logic [7:0]  s1_byte_q, s1_byte_d;
  logic        out_valid_q;
  logic [7:0]  out_data_q;

  logic              accept, s1_adv, is_wr;
  logic              vmem_we, vmem_re, smem_we, smem_re;
  region_e           region;
  logic [VmemAw-1:0] vidx;
  logic [15:0]       vaddr_step;
  logic [7:0]        result;

  vurp_addr_map #(
    .NAME_TABLE_BYTES(NAME_TABLE_BYTES)
  ) u_addr_map (
    .video_address_i(vaddr_q),
    .region_o       (region),
    .index_o        (vidx)
  );

  assign s1_adv    = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept    = req_i.valid && req_i.ready;
  assign is_wr     = req_i.func == FUNC_WRITE;

  assign vaddr_step = vaddr_q + (ctrl_q[CTRL_STEP_BIT] ? STEP_WIDE : STEP_NARROW);

  assign vmem_we = accept && is_wr && req_i.reg_index == REG_DATA && region != REGION_PATTERN;
  assign vmem_re = accept && !is_wr && req_i.reg_index == REG_DATA;
  assign smem_we = accept && is_wr && req_i.reg_index == REG_SPR_DATA;
  assign smem_re = accept && !is_wr && req_i.reg_index == REG_SPR_DATA;

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[vidx] <= req_i.write_data;
    end
    if (vmem_re) begin
      vmem_rd_q <= vmem[vidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      smem[spr_idx_q] <= req_i.write_data;
    end
    if (smem_re) begin
      smem_rd_q <= smem[spr_idx_q];
    end
  end

  always_comb begin
    ctrl_d    = ctrl_q;
    spr_idx_d = spr_idx_q;
    staged_d  = staged_q;
    vaddr_d   = vaddr_q;
    toggle_d  = toggle_q;
    phase_d   = phase_q;
    s1_src_d  = SRC_FIXED;
    s1_byte_d = 8'h00;
    if (is_wr) begin
      unique case (req_i.reg_index)
        REG_CTRL: begin
          ctrl_d          = req_i.write_data;
          staged_d[11:10] = req_i.write_data[1:0];
        end
        REG_SPR_ADDR: spr_idx_d = req_i.write_data;
        REG_SPR_DATA: spr_idx_d = spr_idx_q + 8'd1;
        REG_SCROLL: begin
          if (!toggle_q) begin
            staged_d[4:0] = req_i.write_data[7:3];
          end else begin
            staged_d[14:12] = req_i.write_data[2:0];
            staged_d[9:5]   = req_i.write_data[7:3];
          end
          toggle_d = !toggle_q;
        end
        REG_ADDR: begin
          if (!toggle_q) begin
            staged_d[14:8] = {1'b0, req_i.write_data[5:0]};
          end else begin
            staged_d[7:0] = req_i.write_data;
            vaddr_d       = {1'b0, staged_q[14:8], req_i.write_data};
          end
          toggle_d = !toggle_q;
        end
        REG_DATA: vaddr_d = vaddr_step;
        default: ;
      endcase
    end else begin
      unique case (req_i.reg_index)
        REG_STATUS: begin
          s1_byte_d = phase_q ? 8'h00 : STATUS_FIRST;
          phase_d   = !phase_q;
          toggle_d  = 1'b0;
        end
        REG_SPR_DATA: s1_src_d = SRC_SPRITE;
        REG_DATA: begin
          vaddr_d = vaddr_step;
          unique case (region)
            REGION_PATTERN: begin
              s1_src_d  = SRC_LATCH_EXT;
              s1_byte_d = req_i.pattern_byte;
            end
            REGION_TABLE:   s1_src_d = SRC_LATCH_MEM;
            REGION_PALETTE: s1_src_d = SRC_PALETTE;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result  = latch_q;
    latch_d = latch_q;
    unique case (s1_src_q)
      SRC_FIXED:     result = s1_byte_q;
      SRC_SPRITE:    result = smem_rd_q;
      SRC_LATCH_EXT: latch_d = s1_byte_q;
      SRC_LATCH_MEM: latch_d = vmem_rd_q;
      SRC_PALETTE: begin
        result  = vmem_rd_q;
        latch_d = vmem_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= 8'h00;
      spr_idx_q   <= 8'h00;
      staged_q    <= 15'h0000;
      vaddr_q     <= 16'h0000;
      toggle_q    <= 1'b0;
      phase_q     <= 1'b0;
      latch_q     <= 8'h00;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_q    <= ctrl_d;
        spr_idx_q <= spr_idx_d;
        staged_q  <= staged_d;
        vaddr_q   <= vaddr_d;
        toggle_q  <= toggle_d;
        phase_q   <= phase_d;
      end
      if (s1_adv) begin
        latch_q <= latch_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_src_q  <= s1_src_d;
      s1_byte_q <= s1_byte_d;
    end
    if (s1_adv) begin
      out_data_q <= result;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

endmodule

// File: rtl/vurp_checker.sv
// ----------------------------------------------------------------------------
// vurp_checker
// Port-level checks of the video unit register port, bound to the top level.
// ----------------------------------------------------------------------------
module vurp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_read_data_i
);

  logic req_xfer;

  assign req_xfer = req_valid_i && req_ready_i;

  // A newly valid result always stems from an earlier request transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_xfer, 2))
    else $error("result without a matching request transfer");

  // The request side is held back only by a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request refused while the result side is free");

  // A stalled result keeps its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_data_i))
    else $error("stalled result changed");

endmodule

bind video_unit_register_port vurp_checker u_vurp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_read_data_i(rsp_o.read_data)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the video unit register port. A driver sends bus
// accesses over the request channel and a monitor takes the returned bytes.
// An in-bench model of the register port predicts every returned byte as
// the accesses are generated; the prediction is queued when the access is
// transferred and checked in order against the response channel. Reads are
// steered away from memory entries that hold no written value yet.
// ----------------------------------------------------------------------------
module testbench;
  import vurp_pkg::*;

  localparam int unsigned NT_BYTES = NAME_TABLE_BYTES_DEF;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam int unsigned STIM_ITEMS = 1050;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic       func;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] pattern_byte;
    logic [7:0] read_data;
    logic [3:0] gap;
    logic       drain;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vurp_req_if req_bus ();
  vurp_rsp_if rsp_bus ();

  video_unit_register_port dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Model state of the register port.
  logic [7:0]  ctrl_m = '0;
  logic [7:0]  spr_ptr = '0;
  logic [14:0] tmp_addr = '0;
  logic [15:0] vid_addr = '0;
  logic        toggle_m = 1'b0;
  logic [7:0]  rd_buf = '0;
  logic        status_m = 1'b0;
  logic [7:0]  nt_mem [NT_BYTES];
  logic [7:0]  pal_mem [PALETTE_BYTES];
  logic [7:0]  spr_mem [SPRITE_BYTES];
  bit [NT_BYTES-1:0]      nt_ok = '0;
  bit [PALETTE_BYTES-1:0] pal_ok = '0;
  bit [SPRITE_BYTES-1:0]  spr_ok = '0;

  access_t     pending_q[$];
  logic [7:0]  read_expect_q[$];
  access_t     cur_acc = '0;
  bit          send_busy = 1'b0;
  bit          send_done = 1'b0;
  bit          gap_armed = 1'b0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned took_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned stim_cnt = 0;
  bit          drain_req = 1'b0;

  function automatic region_e region_of(logic [15:0] va);
    if (va[13:0] < NT_START) return REGION_PATTERN;
    if (va[13:0] < PALETTE_START) return REGION_TABLE;
    return REGION_PALETTE;
  endfunction

  // Entries 0x10, 0x14, 0x18 and 0x1C fold onto the backdrop entries.
  function automatic logic [4:0] pal_slot(logic [15:0] va);
    logic [4:0] s;
    s = va[4:0];
    if (s[4] && s[1:0] == 2'b00) s[4] = 1'b0;
    return s;
  endfunction

  function automatic bit fetch_ok();
    case (region_of(vid_addr))
      REGION_TABLE:   return nt_ok[vid_addr[10:0]];
      REGION_PALETTE: return pal_ok[pal_slot(vid_addr)];
      default:        return 1'b1;
    endcase
  endfunction

  function automatic void advance_addr();
    vid_addr = vid_addr + (ctrl_m[CTRL_STEP_BIT] ? STEP_WIDE : STEP_NARROW);
  endfunction

  function automatic logic [7:0] bus_access(access_t acc);
    logic [14:0] t;
    logic [7:0]  r;
    logic [7:0]  d;
    t = tmp_addr;
    r = '0;
    d = acc.write_data;
    if (acc.func == FUNC_WRITE) begin
      case (acc.reg_index)
        REG_CTRL: begin
          ctrl_m = d;
          t[11:10] = d[1:0];
        end
        REG_SPR_ADDR: spr_ptr = d;
        REG_SPR_DATA: begin
          spr_mem[spr_ptr] = d;
          spr_ok[spr_ptr] = 1'b1;
          spr_ptr = spr_ptr + 8'd1;
        end
        REG_SCROLL: begin
          if (!toggle_m) begin
            t[4:0] = d[7:3];
          end else begin
            t[14:12] = d[2:0];
            t[9:5] = d[7:3];
          end
          toggle_m = ~toggle_m;
        end
        REG_ADDR: begin
          if (!toggle_m) begin
            t[13:8] = d[5:0];
            t[14] = 1'b0;
          end else begin
            t[7:0] = d;
            vid_addr = {1'b0, t};
          end
          toggle_m = ~toggle_m;
        end
        REG_DATA: begin
          case (region_of(vid_addr))
            REGION_TABLE: begin
              nt_mem[vid_addr[10:0]] = d;
              nt_ok[vid_addr[10:0]] = 1'b1;
            end
            REGION_PALETTE: begin
              pal_mem[pal_slot(vid_addr)] = d;
              pal_ok[pal_slot(vid_addr)] = 1'b1;
            end
            default: ;
          endcase
          advance_addr();
        end
        default: ;
      endcase
      tmp_addr = t;
    end else begin
      case (acc.reg_index)
        REG_STATUS: begin
          r = status_m ? 8'h00 : STATUS_FIRST;
          status_m = ~status_m;
          toggle_m = 1'b0;
        end
        REG_SPR_DATA: r = spr_mem[spr_ptr];
        REG_DATA: begin
          r = rd_buf;
          case (region_of(vid_addr))
            REGION_TABLE:   rd_buf = nt_mem[vid_addr[10:0]];
            REGION_PALETTE: rd_buf = pal_mem[pal_slot(vid_addr)];
            default:        rd_buf = acc.pattern_byte;
          endcase
          if (region_of(vid_addr) == REGION_PALETTE) r = rd_buf;
          advance_addr();
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Reads that would return a never-written memory entry become writes.
  task automatic add(logic f, logic [2:0] r, logic [7:0] d);
    access_t acc;
    acc = '0;
    acc.func = f;
    acc.reg_index = r;
    acc.write_data = d;
    acc.pattern_byte = 8'($urandom);
    if (acc.func == FUNC_READ && r == REG_DATA && !fetch_ok()) acc.func = FUNC_WRITE;
    if (acc.func == FUNC_READ && r == REG_SPR_DATA && !spr_ok[spr_ptr])
      acc.func = FUNC_WRITE;
    acc.drain = drain_req;
    drain_req = 1'b0;
    acc.gap = ((stim_cnt / 64) % 4 == 0) ? 4'd0 : 4'($urandom_range(0, 8));
    acc.read_data = bus_access(acc);
    if (!(acc.func == FUNC_WRITE && (r == REG_MASK || r == REG_STATUS))) stim_cnt++;
    pending_q.push_back(acc);
  endtask

  function automatic logic [7:0] pick_high();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return {2'($urandom), 1'b0, 5'($urandom)};
    if (sel <= 3) return {2'($urandom), 6'($urandom_range(32, 62))};
    return {2'($urandom), 6'h3F};
  endfunction

  task automatic note_error(string what, logic [7:0] want, logic [7:0] got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("error: %s, transfer %0d: expected %02h, got %02h", what, got_cnt, want, got);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Request driver.
  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      read_expect_q.push_back(cur_acc.read_data);
      took_cnt++;
      send_done = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_READ;
      req_bus.reg_index <= REG_CTRL;
      req_bus.write_data <= '0;
      req_bus.pattern_byte <= '0;
    end else begin
      if (send_busy && send_done) send_busy = 1'b0;
      send_done = 1'b0;
      if (!send_busy && pending_q.size() != 0) begin
        if (!gap_armed) begin
          gap_left = pending_q[0].gap;
          gap_armed = 1'b1;
        end
        if (!(pending_q[0].drain && took_cnt != got_cnt)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            cur_acc = pending_q.pop_front();
            gap_armed = 1'b0;
            send_busy = 1'b1;
          end
        end
      end
      req_bus.valid <= send_busy;
      req_bus.func <= cur_acc.func;
      req_bus.reg_index <= cur_acc.reg_index;
      req_bus.write_data <= cur_acc.write_data;
      req_bus.pattern_byte <= cur_acc.pattern_byte;
    end
  end

  // Response monitor.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got_cnt++;
      if (read_expect_q.size() == 0) begin
        note_error("unexpected transfer", 8'h00, rsp_bus.read_data);
      end else begin
        want = read_expect_q.pop_front();
        if (rsp_bus.read_data !== want) note_error("read_data", want, rsp_bus.read_data);
      end
      hold_left = ((got_cnt / 64) % 4 == 2) ? 0 : $urandom_range(0, 8);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Stimulus.
  initial begin
    int unsigned scen;
    int unsigned n;
    int unsigned next_drain;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  last_hi;
    logic [7:0]  last_lo;
    logic [7:0]  base;

    req_bus.valid = 1'b0;
    req_bus.func = FUNC_READ;
    req_bus.reg_index = REG_CTRL;
    req_bus.write_data = '0;
    req_bus.pattern_byte = '0;
    rsp_bus.ready = 1'b0;
    last_hi = 8'h20;
    last_lo = '0;
    next_drain = 300;

    add(FUNC_READ, REG_STATUS, 8'h00);
    add(FUNC_READ, REG_STATUS, 8'hFF);
    add(FUNC_READ, REG_CTRL, 8'h00);
    add(FUNC_READ, REG_SCROLL, 8'h00);
    add(FUNC_WRITE, REG_CTRL, 8'h00);
    add(FUNC_WRITE, REG_ADDR, 8'h3F);
    add(FUNC_WRITE, REG_ADDR, 8'h10);
    add(FUNC_WRITE, REG_DATA, 8'hFF);
    add(FUNC_WRITE, REG_DATA, 8'h00);
    add(FUNC_WRITE, REG_ADDR, 8'hFF);
    add(FUNC_WRITE, REG_ADDR, 8'h00);
    add(FUNC_READ, REG_DATA, 8'h00);
    add(FUNC_WRITE, REG_CTRL, 8'hFF);
    add(FUNC_WRITE, REG_SPR_ADDR, 8'hFF);
    add(FUNC_WRITE, REG_SPR_DATA, 8'h80);
    add(FUNC_WRITE, REG_SPR_ADDR, 8'hFF);
    add(FUNC_READ, REG_SPR_DATA, 8'h00);
    add(FUNC_WRITE, REG_SCROLL, 8'hFF);
    add(FUNC_WRITE, REG_SCROLL, 8'h00);
    add(FUNC_WRITE, REG_ADDR, 8'h3F);
    add(FUNC_WRITE, REG_ADDR, 8'hFF);
    add(FUNC_WRITE, REG_DATA, 8'h12);
    add(FUNC_READ, REG_DATA, 8'h00);
    add(FUNC_READ, REG_DATA, 8'h00);
    add(FUNC_WRITE, REG_MASK, 8'h55);
    drain_req = 1'b1;

    while (stim_cnt < STIM_ITEMS) begin
      if (stim_cnt >= next_drain) begin
        drain_req = 1'b1;
        next_drain += 300;
      end
      scen = $urandom_range(0, 99);
      if (scen < 40) begin
        // Burst of data writes, then the same span read back.
        hi = pick_high();
        lo = 8'($urandom);
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) add(FUNC_WRITE, REG_CTRL, 8'($urandom));
        if ($urandom_range(0, 4) != 0) add(FUNC_READ, REG_STATUS, 8'($urandom));
        add(FUNC_WRITE, REG_ADDR, hi);
        add(FUNC_WRITE, REG_ADDR, lo);
        repeat (n) add(FUNC_WRITE, REG_DATA, 8'($urandom));
        add(FUNC_READ, REG_STATUS, 8'($urandom));
        add(FUNC_WRITE, REG_ADDR, ($urandom_range(0, 2) == 0) ? (hi ^ 8'h08) : hi);
        add(FUNC_WRITE, REG_ADDR, lo);
        repeat (n + 1) add(FUNC_READ, REG_DATA, 8'($urandom));
        last_hi = hi;
        last_lo = lo;
      end else if (scen < 60) begin
        add(FUNC_READ, REG_STATUS, 8'($urandom));
        hi = ($urandom_range(0, 1) == 0) ? (last_hi ^ 8'h08) : pick_high();
        add(FUNC_WRITE, REG_ADDR, hi);
        add(FUNC_WRITE, REG_ADDR, last_lo + 8'($urandom_range(0, 3)));
        repeat ($urandom_range(1, 10))
          add(1'($urandom_range(0, 1)), REG_DATA, 8'($urandom));
      end else if (scen < 75) begin
        base = 8'($urandom);
        n = $urandom_range(1, 6);
        add(FUNC_WRITE, REG_SPR_ADDR, base);
        repeat (n) add(FUNC_WRITE, REG_SPR_DATA, 8'($urandom));
        for (int unsigned i = 0; i < n; i++) begin
          add(FUNC_WRITE, REG_SPR_ADDR, base + 8'(i));
          add(FUNC_READ, REG_SPR_DATA, 8'($urandom));
        end
      end else if (scen < 85) begin
        add(FUNC_READ, REG_STATUS, 8'($urandom));
        add(FUNC_WRITE, REG_SCROLL, 8'($urandom));
        add(FUNC_WRITE, REG_SCROLL, 8'($urandom));
        if ($urandom_range(0, 1) == 0) add(FUNC_WRITE, REG_ADDR, 8'($urandom));
        if ($urandom_range(0, 1) == 0) add(FUNC_WRITE, REG_CTRL, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          add(1'($urandom_range(0, 1)), 3'($urandom), 8'($urandom));
      end
    end

    while (pending_q.size() != 0 || send_busy) @(posedge clk_i);
    while (read_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/vurp_pkg.sv
rtl/vurp_if.sv
rtl/vurp_addr_map.sv
rtl/video_unit_register_port.sv
rtl/vurp_checker.sv
tb/testbench.sv
